### sv/cdq_pkg.sv
// Shared constants and control types for the circular deque.
package cdq_pkg;

    // Ring store geometry
    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = 5;
    localparam int CAP_W = 5;
    localparam int VAL_W = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(11);

    // Command codes
    localparam logic [2:0] CMD_PUSH_L = 3'd0;
    localparam logic [2:0] CMD_PUSH_R = 3'd1;
    localparam logic [2:0] CMD_POP_L  = 3'd2;
    localparam logic [2:0] CMD_POP_R  = 3'd3;
    localparam logic [2:0] CMD_QUERY  = 3'd4;

    // Status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic step;    // take the request and update head, count, ring
        logic read;    // fetch left and right entries from the ring
        logic load;    // move the result into the output register
    } cdq_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;  // output register can take a result this cycle
    } cdq_stat_t;

endpackage

### sv/circular_deque_top.sv
// Circular deque top level: controller, datapath and checks.
//
// Double-ended queue of 32-bit signed values held in a 16-entry ring. Each
// request pushes at the left or right end, pops from either end, or only
// queries, and gives one result with the status, the left and right values
// (all ones when empty), the empty and full flags and the count. One request
// is worked on at a time: it is taken (ring write), then the two ends are
// fetched from the ring memory's registered read port, then the result
// enters the output register once that register is free; only then is a
// new request taken. The capacity register resets to 11, is clamped into
// 1..16, and writing it empties the deque.
module circular_deque_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [cdq_pkg::CAP_W-1:0]        cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [2:0]                       command,
    input  logic signed [cdq_pkg::VAL_W-1:0] value,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [1:0]                       status,
    output logic signed [cdq_pkg::VAL_W-1:0] left_value,
    output logic signed [cdq_pkg::VAL_W-1:0] right_value,
    output logic                             is_empty,
    output logic                             is_full,
    output logic [cdq_pkg::CNT_W-1:0]        count
);
    import cdq_pkg::*;

    cdq_cmd_t  cmd;
    cdq_stat_t stat;

    // Sequencer
    cdq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // State, ring and output register
    cdq_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .command     (command),
        .value       (value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .left_value  (left_value),
        .right_value (right_value),
        .is_empty    (is_empty),
        .is_full     (is_full),
        .count       (count)
    );

`ifndef SYNTHESIS
    // A taken request blocks the next one for the following cycle
    a_step_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request taken twice in a row");

    // Empty flag agrees with the count
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (is_empty == (count == '0)))
        else $error("empty flag disagrees with count");

    // An empty deque reports all ones at both ends
    a_empty_values: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_empty |-> (left_value == '1) && (right_value == '1))
        else $error("empty deque reports stale values");

    // A refused push only happens on a full deque
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_FULL) |-> is_full && !is_empty)
        else $error("full refusal on a deque that is not full");
`endif

endmodule

### sv/cdq_ctrl.sv
// Sequencing state machine for the circular deque.
module cdq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  cdq_pkg::cdq_stat_t stat,
    output cdq_pkg::cdq_cmd_t  cmd
);
    import cdq_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_LOAD = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Take a request only while idle
    assign in_stall = (state_reg != S_IDLE);

    // Advance through step, read, load
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.step   = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.read   = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (stat.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### sv/cdq_dp.sv
// Datapath of the circular deque: head, count, capacity, ring memory, output register.
module cdq_dp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  cdq_pkg::cdq_cmd_t                cmd,
    output cdq_pkg::cdq_stat_t               stat,
    input  logic                             cfg_we,
    input  logic [cdq_pkg::CAP_W-1:0]        cfg_data,
    input  logic [2:0]                       command,
    input  logic signed [cdq_pkg::VAL_W-1:0] value,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [1:0]                       status,
    output logic signed [cdq_pkg::VAL_W-1:0] left_value,
    output logic signed [cdq_pkg::VAL_W-1:0] right_value,
    output logic                             is_empty,
    output logic                             is_full,
    output logic [cdq_pkg::CNT_W-1:0]        count
);
    import cdq_pkg::*;

    logic [CAP_W-1:0] cap_reg;
    logic [IDX_W-1:0] head_reg,   head_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic [1:0]       status_reg, status_next;
    logic             out_valid_reg, out_valid_next;

    logic [CAP_W-1:0] cap_eff;
    logic             full_now, empty_now;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [IDX_W+1:0] tail_sum;
    logic [IDX_W+1:0] right_sum;
    logic [IDX_W-1:0] right_idx;
    logic [IDX_W:0]   head_inc;

    logic [VAL_W-1:0] ring_mem [DEPTH];
    logic [VAL_W-1:0] rd_left_reg, rd_right_reg;

    logic [1:0]             status_out_reg;
    logic [VAL_W-1:0]       left_out_reg, right_out_reg;
    logic                   empty_out_reg, full_out_reg;
    logic [CNT_W-1:0]       count_out_reg;

    // Clamp capacity into 1..DEPTH
    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_eff = CAP_W'(1);
        end
        else if (cap_reg > CAP_W'(DEPTH))
        begin
            cap_eff = CAP_W'(DEPTH);
        end
        else
        begin
            cap_eff = cap_reg;
        end
    end

    assign full_now  = (count_reg == CNT_W'(cap_eff));
    assign empty_now = (count_reg == '0);
    assign tail_sum  = (IDX_W+2)'(head_reg) + (IDX_W+2)'(count_reg);
    assign head_inc  = (IDX_W+1)'(head_reg) + (IDX_W+1)'(1);

    // Work out the next head, count, status and ring write for a request
    always_comb
    begin
        head_next   = head_reg;
        count_next  = count_reg;
        status_next = ST_DONE;
        wr_en       = 1'b0;
        wr_idx      = head_reg;
        case (command)
            CMD_PUSH_L:
            begin
                if (full_now)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    head_next  = (head_reg == '0) ? IDX_W'(cap_eff - CAP_W'(1))
                                                  : head_reg - IDX_W'(1);
                    wr_en      = 1'b1;
                    wr_idx     = head_next;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            CMD_PUSH_R:
            begin
                if (full_now)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_idx     = (tail_sum >= (IDX_W+2)'(cap_eff))
                               ? IDX_W'(tail_sum - (IDX_W+2)'(cap_eff))
                               : IDX_W'(tail_sum);
                    count_next = count_reg + CNT_W'(1);
                end
            end
            CMD_POP_L:
            begin
                if (empty_now)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    head_next  = (head_inc >= (IDX_W+1)'(cap_eff)) ? '0 : IDX_W'(head_inc);
                    count_next = count_reg - CNT_W'(1);
                end
            end
            CMD_POP_R:
            begin
                if (empty_now)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            CMD_QUERY:
            begin
                status_next = ST_DONE;
            end
            default:
            begin
                status_next = ST_DONE;
            end
        endcase
    end

    // Control registers: capacity write empties the deque
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= CAP_RESET;
            head_reg  <= '0;
            count_reg <= '0;
        end
        else if (cfg_we)
        begin
            cap_reg   <= cfg_data;
            head_reg  <= '0;
            count_reg <= '0;
        end
        else if (cmd.step)
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    // Hold the status of the request in flight
    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            status_reg <= status_next;
        end
    end

    // Ring memory write
    always_ff @(posedge clk)
    begin
        if (cmd.step && wr_en)
        begin
            ring_mem[wr_idx] <= value;
        end
    end

    // Rightmost slot: head + count - 1, wrapped
    assign right_sum = (IDX_W+2)'(head_reg) + (IDX_W+2)'(count_reg) - (IDX_W+2)'(1);
    assign right_idx = (right_sum >= (IDX_W+2)'(cap_eff))
                     ? IDX_W'(right_sum - (IDX_W+2)'(cap_eff))
                     : IDX_W'(right_sum);

    // Ring memory reads at both ends
    always_ff @(posedge clk)
    begin
        if (cmd.read)
        begin
            rd_left_reg  <= ring_mem[head_reg];
            rd_right_reg <= ring_mem[right_idx];
        end
    end

    // Output register handshake
    assign stat.out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Load the result fields; an empty deque reports all ones
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            status_out_reg <= status_reg;
            left_out_reg   <= empty_now ? '1 : rd_left_reg;
            right_out_reg  <= empty_now ? '1 : rd_right_reg;
            empty_out_reg  <= empty_now;
            full_out_reg   <= full_now;
            count_out_reg  <= count_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_out_reg;
    assign left_value  = left_out_reg;
    assign right_value = right_out_reg;
    assign is_empty    = empty_out_reg;
    assign is_full     = full_out_reg;
    assign count       = count_out_reg;

endmodule
